FILE: hdl/tbc_pkg.sv
// Shared types and character codes for the markup tag balance checker.
// No dependencies; used by tbc_stack_mem and markup_tag_balance_checker.
`timescale 1ns / 1ps

package tbc_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_H     = 8'h68;  // 'h'
  localparam logic [7:0] CH_B     = 8'h62;  // 'b'
  localparam logic [7:0] CH_R     = 8'h72;  // 'r'

  // Strobes from the controller to the stack memories.
  typedef struct packed {
    logic rd_en;
    logic byte_we;
    logic len_we;
  } tbc_mem_ctl_t;

endpackage

FILE: hdl/tbc_stack_mem.sv
// Tag stack storage: one byte memory of rows of tag bytes and one memory of
// row lengths, each with a registered read port and one write port.
// Depends on tbc_pkg for the control struct.
`timescale 1ns / 1ps

module tbc_stack_mem #(
  parameter int STACK_DEPTH = 16,
  parameter int TAG_LEN     = 32
) (
  input  logic                         clk_i,
  input  tbc_pkg::tbc_mem_ctl_t        ctl_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] rd_row_i,
  input  logic [$clog2(TAG_LEN)-1:0]     rd_col_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] wr_row_i,
  input  logic [$clog2(TAG_LEN)-1:0]     wr_col_i,
  input  logic [7:0]                     wr_byte_i,
  input  logic [$clog2(TAG_LEN+1)-1:0]   wr_len_i,
  output logic [7:0]                     rd_byte_o,
  output logic [$clog2(TAG_LEN+1)-1:0]   rd_len_o
);

  localparam int LW = $clog2(TAG_LEN + 1);

  logic [7:0]    tag_mem [STACK_DEPTH][TAG_LEN];
  logic [LW-1:0] len_mem [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.byte_we) begin
      tag_mem[wr_row_i][wr_col_i] <= wr_byte_i;
    end
    if (ctl_i.rd_en) begin
      rd_byte_o <= tag_mem[rd_row_i][rd_col_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.len_we) begin
      len_mem[wr_row_i] <= wr_len_i;
    end
    if (ctl_i.rd_en) begin
      rd_len_o <= len_mem[rd_row_i];
    end
  end

endmodule

FILE: hdl/markup_tag_balance_checker.sv
// Markup tag balance checker: each byte is accepted in the idle state and
// resolved in the processing state, once the registered tag stack read is back.
// The verdict is registered on the master side when the last byte is resolved.
// A finished verdict may wait while the next document's bytes are taken.
// Reset clears control state only; the stack memories need no clearing pass.
// Depends on tbc_pkg and tbc_stack_mem.
`timescale 1ns / 1ps

module markup_tag_balance_checker #(
  parameter int STACK_DEPTH = 16,
  parameter int TAG_LEN     = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // last_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] well_formed, [7:1] zero
);

  localparam int RW   = $clog2(STACK_DEPTH);
  localparam int CW   = $clog2(TAG_LEN);
  localparam int LW   = $clog2(TAG_LEN + 1);
  localparam int CNTW = $clog2(STACK_DEPTH + 1);

  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(STACK_DEPTH);
  localparam logic [LW-1:0]   TAG_C   = LW'(TAG_LEN);

  typedef enum logic {
    S_IDLE,
    S_PROC
  } state_e;

  state_e          state_q, state_d;
  logic [7:0]      char_q, char_d;
  logic            last_q, last_d;
  logic            inside_q, inside_d;
  logic            err_q, err_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [LW-1:0]   len_q, len_d;
  logic            close_q, close_d;
  logic            void_q, void_d;
  logic            mism_q, mism_d;
  logic            ovalid_q, ovalid_d;
  logic            owf_q, owf_d;

  tbc_pkg::tbc_mem_ctl_t mem_ctl;
  logic [RW-1:0]   rd_row, wr_row;
  logic [CW-1:0]   rd_col, wr_col;
  logic [LW-1:0]   len_m1;
  logic [CNTW-1:0] cnt_m1;
  logic [7:0]      rd_byte;
  logic [LW-1:0]   rd_len;

  logic          accept, go;
  logic          start, stored, too_long, fin;
  logic          byte_miss, len_miss, is_void, room;
  logic [LW-1:0] new_len;
  logic          err_t;

  assign accept = s_axis_tvalid && s_axis_tready;
  // A last byte stalls in its resolve state while a previous verdict waits.
  assign go = (state_q == S_PROC) && !(last_q && ovalid_q && !m_axis_tready);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, owf_q};

  // Reads look at the top entry, at the column paired with the incoming byte.
  assign cnt_m1 = cnt_q - CNTW'(1);
  assign len_m1 = len_q - LW'(1);
  assign rd_row = cnt_m1[RW-1:0];
  assign rd_col = len_m1[CW-1:0];

  assign start    = !inside_q && (char_q == tbc_pkg::CH_LT);
  assign stored   = inside_q && (len_q < TAG_C);
  assign too_long = inside_q && !stored;
  assign fin      = inside_q && (char_q == tbc_pkg::CH_GT);
  assign new_len  = stored ? len_q + LW'(1) : len_q;
  assign room     = (cnt_q < DEPTH_C);

  // Closing-tag byte at position p is checked against entry byte p-1.
  assign byte_miss = stored && close_q && (len_q >= LW'(2)) && (len_q <= rd_len) &&
                     (rd_byte != char_q);
  assign len_miss  = ({1'b0, new_len} != ({1'b0, rd_len} + (LW+1)'(1)));
  assign is_void   = (new_len == LW'(4)) && void_q;
  assign err_t     = err_q || too_long;

  // Every stored byte is written to the row above the top while there is room;
  // only a push makes that row part of the stack, so speculative writes are harmless.
  assign wr_row = cnt_q[RW-1:0];
  assign wr_col = start ? CW'(0) : len_q[CW-1:0];

  always_comb begin
    mem_ctl.rd_en   = accept;
    mem_ctl.byte_we = go && (start || stored) && room;
    mem_ctl.len_we  = go && fin && !err_t && !close_q && !is_void && room;
  end

  tbc_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH),
    .TAG_LEN    (TAG_LEN)
  ) u_stack_mem (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .rd_row_i (rd_row),
    .rd_col_i (rd_col),
    .wr_row_i (wr_row),
    .wr_col_i (wr_col),
    .wr_byte_i(char_q),
    .wr_len_i (new_len),
    .rd_byte_o(rd_byte),
    .rd_len_o (rd_len)
  );

  always_comb begin
    state_d  = state_q;
    char_d   = char_q;
    last_d   = last_q;
    inside_d = inside_q;
    err_d    = err_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    close_d  = close_q;
    void_d   = void_q;
    mism_d   = mism_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    owf_d    = owf_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          char_d  = s_axis_tdata;
          last_d  = s_axis_tlast;
          state_d = S_PROC;
        end
      end
      S_PROC: begin
        if (go) begin
          state_d = S_IDLE;
          if (start) begin
            inside_d = 1'b1;
            len_d    = LW'(1);
            close_d  = 1'b0;
            void_d   = 1'b0;
            mism_d   = 1'b0;
          end else if (inside_q) begin
            err_d  = err_t;
            len_d  = new_len;
            mism_d = mism_q || byte_miss;
            if (len_q == LW'(1)) begin
              close_d = (char_q == tbc_pkg::CH_SLASH);
              void_d  = (char_q == tbc_pkg::CH_H) || (char_q == tbc_pkg::CH_B);
            end else if (len_q == LW'(2)) begin
              void_d = void_q && (char_q == tbc_pkg::CH_R);
            end
            if (fin) begin
              inside_d = 1'b0;
              len_d    = '0;
              // Once an error is seen the stack is frozen for the document.
              if (!err_t) begin
                if (close_q) begin
                  if (cnt_q == '0) begin
                    err_d = 1'b1;
                  end else if (mism_q || byte_miss || len_miss) begin
                    err_d = 1'b1;
                  end else begin
                    cnt_d = cnt_m1;
                  end
                end else if (!is_void) begin
                  if (room) begin
                    cnt_d = cnt_q + CNTW'(1);
                  end else begin
                    err_d = 1'b1;
                  end
                end
              end
            end
          end
          if (last_q) begin
            ovalid_d = 1'b1;
            owf_d    = (cnt_d == '0) && !err_d && !inside_d;
            inside_d = 1'b0;
            err_d    = 1'b0;
            cnt_d    = '0;
            len_d    = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      inside_q <= 1'b0;
      err_q    <= 1'b0;
      cnt_q    <= '0;
      len_q    <= '0;
      ovalid_q <= 1'b0;
      owf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      inside_q <= inside_d;
      err_q    <= err_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      ovalid_q <= ovalid_d;
      owf_q    <= owf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    last_q  <= last_d;
    close_q <= close_d;
    void_q  <= void_d;
    mism_q  <= mism_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("tag stack count exceeds its depth");

  a_accept_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_PROC))
    else $error("accepted request did not enter its resolve cycle");

  a_verdict_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> ($past(state_q) == S_PROC) && $past(last_q))
    else $error("verdict raised without a last byte");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && last_q) |=> (cnt_q == '0) && !err_q && !inside_q && ovalid_q)
    else $error("state not cleared after verdict");

endmodule

FILE: sim/tb.sv
// Testbench for markup_tag_balance_checker: streams directed and random markup
// documents and checks every verdict against a scoreboard that tracks the tag stack.
// Depends on tbc_pkg and the checker RTL.
`timescale 1ns / 1ps

module tb;

  localparam int STACK_DEPTH = 16;
  localparam int TAG_LEN     = 32;
  localparam int GEN_DEPTH   = 20;
  localparam int LONG_HOLD   = 400;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] char_code
  logic       s_axis_tlast;   // last_char
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [0] well_formed, [7:1] zero

  markup_tag_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .TAG_LEN    (TAG_LEN)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Tracks the tag stack of the document in flight and queues one verdict per document.
  class verdict_scoreboard;
    logic [7:0]  stacked [STACK_DEPTH][TAG_LEN];
    int unsigned stacked_len [STACK_DEPTH];
    int unsigned depth;
    logic [7:0]  tag_buf [TAG_LEN];
    int unsigned tag_len;
    bit          in_tag;
    bit          broken;
    bit          verdicts [$];
    int unsigned n_docs, n_checked, n_good, n_errors;

    function void clear_doc();
      depth   = 0;
      tag_len = 0;
      in_tag  = 1'b0;
      broken  = 1'b0;
    endfunction

    function void end_tag();
      int unsigned top;
      if (broken) return;
      if (tag_len >= 2 && tag_buf[1] == tbc_pkg::CH_SLASH) begin
        if (depth == 0) begin
          broken = 1'b1;
          return;
        end
        top = depth - 1;
        if (stacked_len[top] + 1 != tag_len) begin
          broken = 1'b1;
          return;
        end
        for (int i = 1; i < stacked_len[top]; i++) begin
          if (stacked[top][i] != tag_buf[i + 1]) begin
            broken = 1'b1;
            return;
          end
        end
        depth = top;
      end else begin
        // Void tags never reach the stack.
        if (tag_len == 4 && tag_buf[0] == tbc_pkg::CH_LT && tag_buf[2] == tbc_pkg::CH_R &&
            tag_buf[3] == tbc_pkg::CH_GT &&
            (tag_buf[1] == tbc_pkg::CH_H || tag_buf[1] == tbc_pkg::CH_B)) return;
        if (depth >= STACK_DEPTH) begin
          broken = 1'b1;
          return;
        end
        for (int i = 0; i < tag_len; i++) stacked[depth][i] = tag_buf[i];
        stacked_len[depth] = tag_len;
        depth++;
      end
    endfunction

    function void note_byte(logic [7:0] c, bit last);
      if (!in_tag) begin
        if (c == tbc_pkg::CH_LT) begin
          in_tag     = 1'b1;
          tag_buf[0] = c;
          tag_len    = 1;
        end
      end else begin
        if (tag_len < TAG_LEN) begin
          tag_buf[tag_len] = c;
          tag_len++;
        end else begin
          broken = 1'b1;
        end
        if (c == tbc_pkg::CH_GT) begin
          end_tag();
          in_tag  = 1'b0;
          tag_len = 0;
        end
      end
      if (last) begin
        if (in_tag) broken = 1'b1;
        verdicts.push_back(depth == 0 && !broken);
        n_docs++;
        clear_doc();
      end
    endfunction

    function void check_verdict(logic [7:0] data);
      bit want;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual %b", $time, data[0]);
        n_errors++;
        return;
      end
      want = verdicts.pop_front();
      n_checked++;
      if (want) n_good++;
      if (data[0] !== want) begin
        $display("%0t: well_formed mismatch, expected %0d, actual %b", $time, want, data[0]);
        n_errors++;
      end
    endfunction
  endclass

  verdict_scoreboard sb = new;

  int unsigned src_idle;
  int unsigned sink_idle;
  bit          hold_go;
  int unsigned n_items;

  logic [7:0] doc_q [$];
  logic [7:0] gen_name [GEN_DEPTH][TAG_LEN];
  int         gen_len [GEN_DEPTH];
  int         gen_depth;

  task automatic send_byte(input logic [7:0] c, input bit last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(c, last);
    n_items++;
  endtask

  task automatic send_doc();
    foreach (doc_q[i]) send_byte(doc_q[i], i == doc_q.size() - 1);
  endtask

  // Sender stops offering until every verdict in flight has been checked.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.verdicts.size() != 0) @(posedge clk_i);
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endfunction

  function automatic void make_name(int slot);
    logic [7:0] c;
    // Mostly short names; some long enough that the closing tag overruns TAG_LEN.
    gen_len[slot] = ($urandom_range(0, 9) == 0) ? $urandom_range(27, 31) : $urandom_range(0, 4);
    for (int i = 0; i < gen_len[slot]; i++) begin
      if ($urandom_range(0, 4) < 3) begin
        c = 8'h61 + 8'($urandom_range(0, 3));
      end else begin
        do c = 8'($urandom_range(1, 255));
        while (c == tbc_pkg::CH_GT || (i == 0 && c == tbc_pkg::CH_SLASH));
      end
      gen_name[slot][i] = c;
    end
  endfunction

  function automatic void open_new();
    if (gen_depth >= GEN_DEPTH) return;
    make_name(gen_depth);
    doc_q.push_back(tbc_pkg::CH_LT);
    for (int i = 0; i < gen_len[gen_depth]; i++) doc_q.push_back(gen_name[gen_depth][i]);
    doc_q.push_back(tbc_pkg::CH_GT);
    gen_depth++;
  endfunction

  function automatic void close_top(bit corrupt);
    int k;
    if (gen_depth == 0) begin
      push_str("</a>");
      return;
    end
    gen_depth--;
    doc_q.push_back(tbc_pkg::CH_LT);
    doc_q.push_back(tbc_pkg::CH_SLASH);
    for (int i = 0; i < gen_len[gen_depth]; i++) doc_q.push_back(gen_name[gen_depth][i]);
    if (corrupt) begin
      if (gen_len[gen_depth] == 0 || $urandom_range(0, 1)) begin
        doc_q.push_back(8'h7A);
      end else begin
        k = doc_q.size() - 1 - $urandom_range(0, gen_len[gen_depth] - 1);
        doc_q[k] = (doc_q[k] == 8'h7A) ? 8'h79 : 8'h7A;
      end
    end
    doc_q.push_back(tbc_pkg::CH_GT);
  endfunction

  function automatic void emit_text();
    logic [7:0] c;
    repeat ($urandom_range(1, 3)) begin
      do c = 8'($urandom_range(0, 255)); while (c == tbc_pkg::CH_LT);
      doc_q.push_back(c);
    end
  endfunction

  function automatic void build_doc();
    int kind;
    int act;
    doc_q.delete();
    gen_depth = 0;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      // Noise: raw bytes with plenty of angle brackets.
      repeat ($urandom_range(1, 20)) begin
        case ($urandom_range(0, 3))
          0:       doc_q.push_back(tbc_pkg::CH_LT);
          1:       doc_q.push_back(tbc_pkg::CH_GT);
          default: doc_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      if (kind < 25) begin
        // Deep nesting, around the stack limit.
        repeat ($urandom_range(14, 18)) open_new();
      end else begin
        repeat ($urandom_range(0, 12)) begin
          act = $urandom_range(0, 9);
          if (act < 4) open_new();
          else if (act < 7) close_top(1'b0);
          else if (act < 8) push_str($urandom_range(0, 1) ? "<hr>" : "<br>");
          else emit_text();
        end
      end
      if ($urandom_range(0, 99) < 85) begin
        while (gen_depth > 0) close_top(1'b0);
      end
      case ($urandom_range(0, 19))
        0:       close_top(1'b1);
        1:       push_str("<a");
        default: ;
      endcase
    end
    if (doc_q.size() == 0) emit_text();
  endfunction

  task automatic run_random(int unsigned upto);
    while (n_items < upto) begin
      build_doc();
      send_doc();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
  end

  // Receiver: random stalls, plus one long hold counted here on request.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    hold_go       = 1'b0;
    n_items       = 0;
    src_idle      = 16;
    sink_idle     = 64;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: byte extremes, a matched pair, void tags, stray close, mismatch, open tag at the end.
    doc_q = '{8'h00, 8'hFF};
    send_doc();
    doc_q.delete(); push_str("<a></a>");  send_doc();
    doc_q.delete(); push_str("<br><hr>"); send_doc();
    doc_q.delete(); push_str("</a>");     send_doc();
    doc_q.delete(); push_str("<a></b>");  send_doc();
    doc_q.delete(); push_str("<a");       send_doc();

    run_random(330);
    src_idle  = 64;
    sink_idle = 16;
    run_random(660);
    src_idle  = 0;
    sink_idle = 0;

    // The receiver holds off while documents keep coming, so the input backs up.
    hold_go = 1'b1;
    repeat (6) begin
      build_doc();
      send_doc();
    end
    wait_drained();
    run_random(1000);
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Streamed %0d documents (%0d bytes); checked %0d verdicts, %0d well formed,",
             sb.n_docs, n_items, sb.n_checked, sb.n_good);
    $display("covering nesting, void tags, mismatches, overflow, long and unterminated tags.");
    if (sb.n_errors == 0 && sb.verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
